FILE: hdl/fst_pkg.sv
package fst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W = 32;
  localparam int HELD_W = 7;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP = 1'b1;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [VALUE_W-1:0] PUSH_VALUE = 32'sd0;

  typedef enum logic [1:0] {
    ST_PUSH_OK   = 2'd0,
    ST_POP_OK    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    status_t                   status;
    logic [HELD_W-1:0]         held_count;
  } result_t;

endpackage

FILE: hdl/fst_in_if.sv
interface fst_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

FILE: hdl/fst_out_if.sv
interface fst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic [6:0]         held_count;

  modport source (output valid, output popped_value, output status, output held_count,
                  input ready);
  modport sink (input valid, input popped_value, input status, input held_count,
                output ready);
endinterface

FILE: hdl/fst_mem.sv
module fst_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6,
  parameter int DW = 39
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/fst_ctrl.sv
module fst_ctrl #(
  parameter int CAPACITY = fst_pkg::CAPACITY_DEF,
  parameter int AW = $clog2(CAPACITY),
  parameter int CW = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  fst_in_if.sink                 req,
  output logic                   res_valid,
  input  logic                   res_free,
  output fst_pkg::result_t       res,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [32+CW-1:0]       mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  input  logic [32+CW-1:0]       mem_rdata
);
  import fst_pkg::*;

  seq_state_t state, state_next;

  logic                      op;
  logic signed [VALUE_W-1:0] val;
  logic [CW-1:0]             count;
  logic [CW-1:0]             max_level;
  logic [CW-1:0]             idx;
  logic                      pend;
  logic [AW-1:0]             pidx;
  logic [CW-1:0]             copies;
  logic                      found;
  logic                      multi;
  logic [AW-1:0]             pos;
  logic signed [VALUE_W-1:0] hit_value;
  status_t                   status;

  logic                      accept;
  logic                      full;
  logic                      issue;
  logic                      walk_done;
  logic [VALUE_W-1:0]        rd_value;
  logic [CW-1:0]             rd_level;
  logic [CW-1:0]             new_level;

  assign accept    = req.valid && req.ready;
  assign full      = count >= CW'(CAPACITY);
  assign issue     = (state == S_SCAN || state == S_SHIFT) && idx < count;
  assign walk_done = !pend && idx >= count;
  assign rd_value  = mem_rdata[CW +: VALUE_W];
  assign rd_level  = mem_rdata[CW-1:0];
  assign new_level = copies + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((req.mode == MODE_PUSH && full) || (req.mode == MODE_POP && count == '0)) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (walk_done) begin
          if (op == MODE_POP && found) begin
            state_next = S_SHIFT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        if (walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    res_valid = (state == S_FINISH);
    res.popped_value = hit_value;
    res.status = status;
    res.held_count = HELD_W'(count);
    mem_re = issue;
    mem_raddr = idx[AW-1:0];
    mem_we = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = {val, new_level};
    case (state)
      S_SCAN: begin
        mem_we = walk_done && op == MODE_PUSH;
      end
      S_SHIFT: begin
        mem_we = pend;
        mem_waddr = pidx - 1'b1;
        mem_wdata = mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      max_level <= '0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op <= req.mode;
            val <= req.value;
            idx <= '0;
            pend <= 1'b0;
            copies <= '0;
            found <= 1'b0;
            multi <= 1'b0;
            if (req.mode == MODE_PUSH) begin
              status <= full ? ST_PUSH_FULL : ST_PUSH_OK;
              hit_value <= PUSH_VALUE;
            end else begin
              status <= ST_POP_EMPTY;
              hit_value <= EMPTY_VALUE;
            end
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            pidx <= idx[AW-1:0];
            idx <= idx + 1'b1;
          end
          if (pend) begin
            if (op == MODE_PUSH) begin
              if (rd_value == val) begin
                copies <= copies + 1'b1;
              end
            end else if (rd_level == max_level) begin
              found <= 1'b1;
              multi <= found;
              pos <= pidx;
              hit_value <= rd_value;
            end
          end
          if (walk_done) begin
            if (op == MODE_PUSH) begin
              count <= count + 1'b1;
              if (new_level > max_level) begin
                max_level <= new_level;
              end
            end else if (found) begin
              idx <= CW'(pos) + 1'b1;
              pend <= 1'b0;
            end
          end
        end
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            pidx <= idx[AW-1:0];
            idx <= idx + 1'b1;
          end
          if (walk_done) begin
            count <= count - 1'b1;
            status <= ST_POP_OK;
            if (!multi && max_level != '0) begin
              max_level <= max_level - 1'b1;
            end
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    max_level <= count)
    else $error("max level above entry count");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !res_free |=> state == S_FINISH && $stable(res))
    else $error("result lost while output busy");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_SHIFT))
    else $error("memory write outside scan or shift");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write hit same entry");

endmodule

FILE: hdl/max_frequency_stack_core.sv
// frequency stack of 32-bit signed values
// req channel: mode 0 pushes value, mode 1 pops the most frequent value,
// ties broken toward the most recently pushed entry
// rsp channel: one word per request with popped_value, status and
// held_count (entries held after the request, modulo 128)
// status: 0 push ok, 1 pop ok, 2 pop on empty, 3 push dropped (full)
// entries live in one memory of CAPACITY words with a registered read;
// a walk makes one memory read per cycle; a push walks the held entries
// once; a pop walks them once to find its entry, then walks the entries
// after it in a second pass that moves them down to close the gap
// empty pop or full push: no walk of the memory
// one request is in work at a time; req.ready is high only when idle
// rsp is held in an output register; while the receiver stalls the next
// finished word waits in the sequencer and no new request is taken
// reset (rst, synchronous) empties the stack at once, no clearing pass
module max_frequency_stack_core #(
  parameter int CAPACITY = fst_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  fst_in_if.sink    req,
  fst_out_if.source rsp
);
  import fst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = VALUE_W + CW;

  result_t       res;
  logic          res_valid;
  logic          res_free;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  assign res_free = !rsp.valid || rsp.ready;

  fst_ctrl #(
    .CAPACITY(CAPACITY),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res_valid(res_valid),
    .res_free(res_free),
    .res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fst_mem #(
    .DEPTH(CAPACITY),
    .AW(AW),
    .DW(DW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      rsp.popped_value <= res.popped_value;
      rsp.status <= res.status;
      rsp.held_count <= res.held_count;
    end
  end

endmodule
